>>> hw/rtl/three_voice_sound_generator_core_defines.svh
// Assertion macros for the sound generator RTL.
`ifndef THREE_VOICE_SOUND_GENERATOR_CORE_DEFINES_SVH
`define THREE_VOICE_SOUND_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TVSG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tvsg assertion failed");
`define TVSG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tvsg assertion failed");
`else
`define TVSG_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TVSG_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/tvsg_pkg.sv
// Shared types, constants and the volume map of the sound generator.
package tvsg_pkg;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [3:0] REG_NOISE_PER = 4'd6;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_VOL_A     = 4'd8;
    localparam logic [3:0] REG_VOL_B     = 4'd9;
    localparam logic [3:0] REG_VOL_C     = 4'd10;
    localparam logic [3:0] REG_ENV_LO    = 4'd11;
    localparam logic [3:0] REG_ENV_HI    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

    localparam int unsigned ENV_HOLD_BIT   = 0;
    localparam int unsigned ENV_ALT_BIT    = 1;
    localparam int unsigned ENV_ATTACK_BIT = 2;
    localparam int unsigned ENV_CONT_BIT   = 3;

    localparam logic [17:0] NOISE_TAP = 18'h28000;

    localparam int unsigned DIVIDEND_W = 17;
    localparam int unsigned DIVISOR_W  = 16;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quot;
        logic [DIVISOR_W-1:0]  rem;
    } div_rsp_t;

    function automatic logic [4:0] vol_map(input logic [3:0] vol);
        logic [4:0] lvl;
        unique case (vol)
            4'd0:  lvl = 5'd0;
            4'd1:  lvl = 5'd0;
            4'd2:  lvl = 5'd0;
            4'd3:  lvl = 5'd1;
            4'd4:  lvl = 5'd1;
            4'd5:  lvl = 5'd1;
            4'd6:  lvl = 5'd2;
            4'd7:  lvl = 5'd3;
            4'd8:  lvl = 5'd4;
            4'd9:  lvl = 5'd6;
            4'd10: lvl = 5'd8;
            4'd11: lvl = 5'd10;
            4'd12: lvl = 5'd14;
            4'd13: lvl = 5'd19;
            4'd14: lvl = 5'd24;
            default: lvl = 5'd31;
        endcase
        return lvl;
    endfunction

endpackage

>>> hw/rtl/tvsg_divider.sv
// Shared restoring divider: one quotient bit per cycle.
module tvsg_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  tvsg_pkg::div_req_t req,
    output tvsg_pkg::div_rsp_t rsp
);
    import tvsg_pkg::*;

    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [4:0]            cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  ge;
    logic [DIVISOR_W:0]    diff;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
                quot_reg <= '0;
                cnt_reg  <= 5'(DIVIDEND_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                dvd_reg  <= {dvd_reg[DIVIDEND_W-2:0], 1'b0};
                quot_reg <= {quot_reg[DIVIDEND_W-2:0], ge};
                rem_reg  <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                cnt_reg  <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> hw/rtl/tvsg_noise.sv
// 17-bit noise shift register and its output flip-flop.
module tvsg_noise (
    input  logic aclk,
    input  logic aresetn,
    input  logic shift_en,
    output logic level
);
    import tvsg_pkg::*;

    logic [16:0] lfsr_reg;
    logic        level_reg;
    logic [17:0] mixed;

    // Fold the tap in before the shift; bit 17 of the tap lands in bit 16
    assign mixed = {1'b0, lfsr_reg} ^ (lfsr_reg[0] ? NOISE_TAP : 18'h0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg  <= 17'd1;
            level_reg <= 1'b1;
        end else if (shift_en) begin
            if (lfsr_reg[1] ^ lfsr_reg[0]) begin
                level_reg <= ~level_reg;
            end
            lfsr_reg <= mixed[17:1];
        end
    end

    assign level = level_reg;

endmodule

>>> hw/rtl/three_voice_sound_generator_core.sv
// Top level of the three-voice sound generator: registers, sequencer, mixer.
//
//  channel | ports                                        | dir
//  --------+----------------------------------------------+-----
//  input   | s_valid s_ready s_command s_reg_addr         | in
//          | s_reg_data s_step_amount                     |
//  result  | m_valid m_ready m_level_a m_level_b m_level_c | out
//
// A sample runs five counters in turn through the shared divider, shifts the
// noise register once per noise wrap, and then loads the result.
// Reset is synchronous, active low, and clears the register file, counters, tone and envelope state, not the levels.
// A result waits in the output register; the sequencer holds in its last
// state while that register is still full.
module three_voice_sound_generator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [3:0]  s_reg_addr,
    input  logic [7:0]  s_reg_data,
    input  logic [23:0] s_step_amount,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_level_a,
    output logic [4:0]  m_level_b,
    output logic [4:0]  m_level_c
);
    import tvsg_pkg::*;

`include "three_voice_sound_generator_core_defines.svh"

    localparam logic [2:0] K_NOISE = 3'd3;
    localparam logic [2:0] K_ENV   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_DIV, ST_APPLY, ST_NOISE, ST_FINISH
    } state_t;

    state_t      state_reg;
    logic [7:0]  regs_reg [16];
    logic [15:0] tone_per_reg [3];
    logic [31:0] cnt_reg [5];
    logic [2:0]  tone_lvl_reg;
    logic [4:0]  noise_per_reg;
    logic [15:0] env_per_reg;
    logic [3:0]  env_pos_reg;
    logic [3:0]  env_shape_reg;
    logic [3:0]  env_vol_reg;
    logic        env_hold_reg;
    logic [2:0]  k_reg;
    logic [15:0] frac_reg;
    logic [23:0] step_reg;
    logic [16:0] wrap_cnt_reg;
    logic        m_valid_reg;
    logic [4:0]  lvl_a_reg;
    logic [4:0]  lvl_b_reg;
    logic [4:0]  lvl_c_reg;

    div_req_t    div_req;
    div_rsp_t    div_rsp;
    logic        noise_en;
    logic        noise_lvl;

    logic        wr_xfer;
    logic        smp_xfer;
    logic [15:0] tone_new [3];
    logic [15:0] tone_fix [3];
    logic [15:0] env_new;
    logic [15:0] env_fix;
    logic [4:0]  noise_fix;
    logic [3:0]  shape_new;
    logic [23:0] add_amt;
    logic [32:0] sum;
    logic [15:0] divisor;
    logic [17:0] hold_sum;
    logic [4:0]  rep_sum;
    logic        rep_att;
    logic        out_free;
    logic [4:0]  lvl [3];
    logic        periods_ok;
    logic        finish_go;

    assign s_ready  = (state_reg == ST_IDLE);
    assign wr_xfer  = s_valid && s_ready && (s_command == CMD_WRITE);
    assign smp_xfer = s_valid && s_ready && (s_command == CMD_SAMPLE);
    assign out_free = !m_valid_reg || m_ready;

    // Candidate periods with the incoming byte merged in
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            tone_new[c][7:0]  = (s_reg_addr == 4'(2 * c)) ? s_reg_data
                                                          : regs_reg[2 * c];
            tone_new[c][15:8] = (s_reg_addr == 4'(2 * c + 1)) ? s_reg_data
                                                              : regs_reg[2 * c + 1];
            tone_fix[c] = (tone_new[c] == 16'd0) ? 16'd1 : tone_new[c];
        end
        env_new[7:0]  = (s_reg_addr == REG_ENV_LO) ? s_reg_data : regs_reg[REG_ENV_LO];
        env_new[15:8] = (s_reg_addr == REG_ENV_HI) ? s_reg_data : regs_reg[REG_ENV_HI];
        env_fix       = (env_new == 16'd0) ? 16'd1 : env_new;
        noise_fix     = (s_reg_data[4:0] == 5'd0) ? 5'd1 : s_reg_data[4:0];
    end

    // Force non-continue shapes into their single-pass hold form
    always_comb begin
        shape_new = s_reg_data[3:0];
        if (!shape_new[ENV_CONT_BIT]) begin
            shape_new[ENV_ALT_BIT]  = shape_new[ENV_ATTACK_BIT];
            shape_new[ENV_HOLD_BIT] = 1'b1;
        end
    end

    // Counter add and divisor select for the counter in work
    always_comb begin
        add_amt = (k_reg == K_ENV) ? {1'b0, step_reg[23:1]} : step_reg;
        sum     = {1'b0, cnt_reg[k_reg]} + {9'd0, add_amt};
        unique case (k_reg)
            3'd0:    divisor = tone_per_reg[0];
            3'd1:    divisor = tone_per_reg[1];
            3'd2:    divisor = tone_per_reg[2];
            K_NOISE: divisor = {11'd0, noise_per_reg};
            default: divisor = env_per_reg;
        endcase
        div_req.start    = (state_reg == ST_LOAD);
        div_req.dividend = sum[32:16];
        div_req.divisor  = divisor;
    end

    // Envelope position arithmetic
    assign hold_sum = {14'd0, env_pos_reg} + {1'b0, div_rsp.quot};
    assign rep_sum  = {1'b0, env_pos_reg} + div_rsp.quot[4:0];
    assign rep_att  = env_shape_reg[ENV_ATTACK_BIT] ^
                      (rep_sum[4] & env_shape_reg[ENV_ALT_BIT]);

    assign noise_en = (state_reg == ST_NOISE);

    // Mixer and volume map per channel
    always_comb begin
        logic       tone_on;
        logic       noise_on;
        logic [3:0] vol;
        for (int c = 0; c < 3; c++) begin
            tone_on  = tone_lvl_reg[c] | regs_reg[REG_MIXER][c];
            noise_on = noise_lvl | regs_reg[REG_MIXER][c + 3];
            vol = regs_reg[int'(REG_VOL_A) + c][4] ? env_vol_reg
                                                   : regs_reg[int'(REG_VOL_A) + c][3:0];
            if (!(tone_on && noise_on)) begin
                vol = 4'd0;
            end
            lvl[c] = vol_map(vol);
        end
    end

    tvsg_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    tvsg_noise u_noise (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (noise_en),
        .level    (noise_lvl)
    );

    // Sequencer, register file and sound state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < 16; i++) begin
                regs_reg[i] <= 8'd0;
            end
            for (int c = 0; c < 3; c++) begin
                tone_per_reg[c] <= 16'd1;
            end
            for (int i = 0; i < 5; i++) begin
                cnt_reg[i] <= 32'd0;
            end
            tone_lvl_reg  <= 3'b111;
            noise_per_reg <= 5'd1;
            env_per_reg   <= 16'd1;
            env_pos_reg   <= 4'd0;
            env_shape_reg <= 4'd0;
            env_vol_reg   <= 4'd0;
            env_hold_reg  <= 1'b0;
            k_reg         <= 3'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Drop the result after its transfer unless a new one loads now
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (wr_xfer) begin
                        regs_reg[s_reg_addr] <= s_reg_data;
                        for (int c = 0; c < 3; c++) begin
                            if (s_reg_addr[3:1] == 3'(c)) begin
                                if (tone_fix[c] < cnt_reg[c][31:16]) begin
                                    cnt_reg[c] <= 32'd0;
                                end
                                tone_per_reg[c] <= tone_fix[c];
                            end
                        end
                        if (s_reg_addr == REG_NOISE_PER) begin
                            if ({11'd0, noise_fix} < cnt_reg[K_NOISE][31:16]) begin
                                cnt_reg[K_NOISE] <= 32'd0;
                            end
                            noise_per_reg <= noise_fix;
                        end
                        if (s_reg_addr == REG_ENV_LO || s_reg_addr == REG_ENV_HI) begin
                            if (env_fix < cnt_reg[K_ENV][31:16]) begin
                                cnt_reg[K_ENV] <= 32'd0;
                            end
                            env_per_reg <= env_fix;
                        end
                        if (s_reg_addr == REG_ENV_SHAPE) begin
                            env_shape_reg <= shape_new;
                            env_pos_reg   <= 4'd0;
                            env_hold_reg  <= 1'b0;
                            env_vol_reg   <= shape_new[ENV_ATTACK_BIT] ? 4'd0 : 4'd15;
                        end
                    end else if (smp_xfer) begin
                        step_reg  <= s_step_amount;
                        k_reg     <= 3'd0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    // Divider takes the whole part; hold the fraction
                    frac_reg  <= sum[15:0];
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    cnt_reg[k_reg] <= {div_rsp.rem, frac_reg};
                    state_reg      <= ST_LOAD;
                    k_reg          <= (k_reg == K_ENV) ? 3'd0 : k_reg + 3'd1;
                    if (k_reg < K_NOISE) begin
                        if (div_rsp.quot[0]) begin
                            tone_lvl_reg[k_reg[1:0]] <= ~tone_lvl_reg[k_reg[1:0]];
                        end
                    end else if (k_reg == K_NOISE) begin
                        if (div_rsp.quot != '0) begin
                            wrap_cnt_reg <= div_rsp.quot;
                            state_reg    <= ST_NOISE;
                        end
                    end else begin
                        state_reg <= ST_FINISH;
                        if (!env_hold_reg) begin
                            if (env_shape_reg[ENV_HOLD_BIT]) begin
                                if (hold_sum >= 18'd16) begin
                                    env_hold_reg <= 1'b1;
                                    env_pos_reg  <= 4'd15;
                                    env_vol_reg  <= (env_shape_reg[ENV_ATTACK_BIT] ^
                                                     env_shape_reg[ENV_ALT_BIT])
                                                    ? 4'd15 : 4'd0;
                                end else begin
                                    env_pos_reg <= hold_sum[3:0];
                                    env_vol_reg <= env_shape_reg[ENV_ATTACK_BIT]
                                                   ? hold_sum[3:0] : ~hold_sum[3:0];
                                end
                            end else begin
                                env_shape_reg[ENV_ATTACK_BIT] <= rep_att;
                                env_pos_reg <= rep_sum[3:0];
                                env_vol_reg <= rep_att ? rep_sum[3:0] : ~rep_sum[3:0];
                            end
                        end
                    end
                end
                ST_NOISE: begin
                    // One shift per wrap
                    wrap_cnt_reg <= wrap_cnt_reg - 17'd1;
                    if (wrap_cnt_reg == 17'd1) begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        lvl_a_reg   <= lvl[0];
                        lvl_b_reg   <= lvl[1];
                        lvl_c_reg   <= lvl[2];
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_level_a = lvl_a_reg;
    assign m_level_b = lvl_b_reg;
    assign m_level_c = lvl_c_reg;

    // Terms for the checks below
    assign periods_ok = (tone_per_reg[0] != 16'd0) && (noise_per_reg != 5'd0) &&
                        (env_per_reg != 16'd0);
    assign finish_go  = (state_reg == ST_FINISH) && out_free;

    `TVSG_ASSERT_IMP(a_done_in_div, aclk, aresetn, div_rsp.done, state_reg == ST_DIV)
    `TVSG_ASSERT_IMP(a_periods_nonzero, aclk, aresetn, 1'b1, periods_ok)
    `TVSG_ASSERT_IMP(a_hold_shape, aclk, aresetn, env_hold_reg, env_shape_reg[ENV_HOLD_BIT])
    `TVSG_ASSERT_NXT(a_finish_loads, aclk, aresetn, finish_go, m_valid_reg && s_ready)

endmodule
